### src/sha_pkg.sv
package sha_pkg;

    localparam int WordW = 64;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_INIT,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

### src/sha_ram.sv
module sha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

### src/sha_round.sv
// One compression round on the working variables a..h.
module sha_round (
    input  logic [63:0] i_v [8],
    input  logic [63:0] i_k,
    input  logic [63:0] i_w,
    output logic [63:0] o_v [8]
);
    logic [63:0] s1, ch, t1, s0, maj;

    always_comb begin
        s1  = sha_pkg::rotr(i_v[4], 14) ^ sha_pkg::rotr(i_v[4], 18) ^ sha_pkg::rotr(i_v[4], 41);
        ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        t1  = i_v[7] + s1 + ch + i_k + i_w;
        s0  = sha_pkg::rotr(i_v[0], 28) ^ sha_pkg::rotr(i_v[0], 34) ^ sha_pkg::rotr(i_v[0], 39);
        maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = t1 + s0 + maj;
    end
endmodule

### src/sha512_hash_engine.sv
// Channel | Dir | Payload
// s_axis  | in  | tdata: message_word[63:0], byte_count[67:64] (72 bits); tuser: last_word
// m_axis  | out | tdata: digest_word[63:0], word_index[66:64] (72 bits); tuser: last_of_digest
// A non-final word is written straight into the message window. A full block of 16 words
// then runs an init step, 80 rounds (each a schedule-read phase, then an update phase)
// and a fold step. A last word adds the padding words at one a cycle, one or two
// compressions, and eight output requests.
// Reset clears all control state; the message window needs no reset.
// The output stage stalls the whole engine while m_axis_tready is low.
module sha512_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // message_word, byte_count, zero fill
    input  logic        s_axis_tuser,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // digest_word, word_index, zero fill
    output logic        m_axis_tuser    // last_of_digest
);
    sha_pkg::t_state r_state, n_state;
    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] rv_next [8];
    logic [3:0]  r_slot;
    logic [6:0]  r_rnd;
    logic        r_phase;
    logic [63:0] r_cnt;
    logic        r_final;   // final word taken: each fold leads to padding or output, not collection
    logic        r_lenpending;
    logic        r_lenok;   // the current block still has room for the length words
    logic        r_need_marker;
    logic [2:0]  r_oidx;

    logic        we;
    logic [3:0]  waddr, ra, rb;
    logic [63:0] wdata, rda, rdb;
    logic [63:0] r_w16, r_w7;  // captured window[t] and window[t+1]
    logic [63:0] sched;

    sha_ram #(.WIDTH(64), .DEPTH(16)) u_win (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .i_raddr_b(rb), .o_rdata_a(rda), .o_rdata_b(rdb)
    );

    sha_round u_round (.i_v(r_v), .i_k(sha_pkg::K[r_rnd]), .i_w(sched), .o_v(rv_next));

    logic [63:0] in_word;
    logic [3:0]  in_n, nn;
    logic        in_last;
    logic [63:0] mask, pad, padword;
    logic [63:0] sg0, sg1;

    assign in_word = s_axis_tdata[63:0];
    assign in_n    = s_axis_tdata[67:64];
    assign in_last = s_axis_tuser;
    assign nn      = (in_n > 4'd8 || !in_last) ? 4'd8 : in_n;

    always_comb begin
        mask = (nn == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {nn, 3'b000});
        pad  = 64'h80 << (7'd56 - {nn, 3'b000});
        padword = (in_word & mask) | pad;
    end

    // Two-phase round: phase 0 captures window[t], window[t+1] and reads
    // window[t+9], window[t+14]; phase 1 uses them while the first pair sits in registers.
    always_comb begin
        sg0 = sha_pkg::rotr(r_w7, 1) ^ sha_pkg::rotr(r_w7, 8) ^ (r_w7 >> 7);
        sg1 = sha_pkg::rotr(rdb, 19) ^ sha_pkg::rotr(rdb, 61) ^ (rdb >> 6);
        sched = (r_rnd < 7'd16) ? r_w16 : (r_w16 + sg0 + rda + sg1);
    end

    logic in_fire, out_fire;
    assign s_axis_tready = (r_state == sha_pkg::ST_COLLECT);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == sha_pkg::ST_OUT);
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {5'd0, r_oidx, r_h[r_oidx]};
    assign m_axis_tuser = (r_oidx == 3'd7);

    logic [63:0] padval;
    always_comb begin
        if (r_need_marker)                              padval = 64'h8000000000000000;
        else if (r_slot == 4'd15 && r_lenpending && r_lenok) padval = r_cnt;
        else                                            padval = 64'd0;
    end

    always_comb begin
        n_state = r_state;
        we = 1'b0;
        waddr = r_slot;
        wdata = in_word;
        ra = r_rnd[3:0];
        rb = r_rnd[3:0] + 4'd1;
        case (r_state)
            sha_pkg::ST_COLLECT: begin
                if (in_fire) begin
                    we = 1'b1;
                    if (in_last && nn != 4'd8) wdata = padword;
                    if (r_slot == 4'd15) n_state = sha_pkg::ST_INIT;
                    else if (in_last) n_state = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD: begin
                we = 1'b1;
                wdata = padval;
                if (r_slot == 4'd15) n_state = sha_pkg::ST_INIT;
            end
            sha_pkg::ST_INIT: n_state = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND: begin
                if (r_phase) begin
                    we = (r_rnd >= 7'd16);
                    waddr = r_rnd[3:0];
                    wdata = sched;
                    ra = r_rnd[3:0] + 4'd1;
                    rb = r_rnd[3:0] + 4'd2;
                    if (r_rnd == 7'd79) n_state = sha_pkg::ST_FOLD;
                end else begin
                    ra = r_rnd[3:0] + 4'd9;
                    rb = r_rnd[3:0] + 4'd14;
                end
            end
            sha_pkg::ST_FOLD: begin
                if (!r_final) n_state = sha_pkg::ST_COLLECT;
                else if (r_lenpending) n_state = sha_pkg::ST_PAD;
                else n_state = sha_pkg::ST_OUT;
            end
            sha_pkg::ST_OUT: if (out_fire && r_oidx == 3'd7) n_state = sha_pkg::ST_COLLECT;
            default: n_state = sha_pkg::ST_COLLECT;
        endcase
    end

    // Reads are issued in the phase before their data is used: phase 0 latches window[t], window[t+1]
    // requested in the previous phase 1 (or INIT), phase 1 consumes t+9, t+14.
    always_ff @(posedge i_clk) begin
        if (r_state == sha_pkg::ST_ROUND && !r_phase) begin
            r_w16 <= rda;
            r_w7  <= rdb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_COLLECT;
            r_slot  <= 4'd0;
            r_rnd   <= 7'd0;
            r_phase <= 1'b0;
            r_cnt   <= 64'd0;
            r_final <= 1'b0;
            r_lenpending <= 1'b0;
            r_lenok <= 1'b0;
            r_oidx  <= 3'd0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::IV[i];
                r_v[i] <= 64'd0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                sha_pkg::ST_COLLECT: begin
                    if (in_fire) begin
                        r_slot <= r_slot + 4'd1;
                        r_cnt  <= r_cnt + {57'd0, nn, 3'b000};
                        if (in_last) begin
                            r_final <= 1'b1;
                            r_lenpending <= 1'b1;
                            // The length needs slots 14 and 15 free after the marker byte.
                            r_lenok <= (nn == 4'd8) ? (r_slot <= 4'd12) : (r_slot <= 4'd13);
                        end
                    end
                end
                sha_pkg::ST_PAD: begin
                    r_slot <= r_slot + 4'd1;
                    if (r_slot == 4'd15 && r_lenok && !r_need_marker) r_lenpending <= 1'b0;
                end
                sha_pkg::ST_INIT: begin
                    r_rnd <= 7'd0;
                    r_phase <= 1'b0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                sha_pkg::ST_ROUND: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        for (int i = 0; i < 8; i++) r_v[i] <= rv_next[i];
                        r_rnd <= r_rnd + 7'd1;
                    end
                end
                sha_pkg::ST_FOLD: begin
                    r_rnd <= 7'd0;
                    r_lenok <= 1'b1;
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                end
                sha_pkg::ST_OUT: begin
                    if (out_fire) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::IV[i];
                            r_cnt <= 64'd0;
                            r_slot <= 4'd0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // A full final word still needs its marker word written during padding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_need_marker <= 1'b0;
        else if (in_fire && in_last && nn == 4'd8) r_need_marker <= 1'b1;
        else if (r_state == sha_pkg::ST_PAD) r_need_marker <= 1'b0;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_oidx == 3'd7 |=> r_state == sha_pkg::ST_COLLECT)
        else $error("digest did not end after eight words");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sha_pkg::ST_ROUND |-> r_rnd < 7'd80)
        else $error("round index overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken during output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_need_marker |-> r_state != sha_pkg::ST_OUT)
        else $error("marker still pending at output");
endmodule
